@@ rtl/mftb_pkg.sv @@
// Shared constants for the mesh face table builder.
// Holds the result status codes and the cell type limits.
// No dependencies.
package mftb_pkg;

    localparam int STATUS_BITS = 3;
    localparam int TYPE_BITS   = 8;

    localparam logic [STATUS_BITS-1:0] ST_NEW_FACE  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NBR_SET   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_OWNER_SET = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_SKIPPED   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    localparam logic [TYPE_BITS-1:0] TYPE_VERTEX_LIMIT = 8'd2;
    localparam logic [TYPE_BITS-1:0] TYPE_LINE_LIMIT   = 8'd5;

endpackage

@@ rtl/mesh_face_table_builder_top.sv @@
// Top level of the mesh face table builder: edge deduplication into a face table.
// Holds the face memory, the scan sequencer and the output register.
// Depends on mftb_pkg.
//
// Channel  Dir  tdata (low bit up)                                     tuser
// s_axis   in   cell_id, face_slot, node_a, node_b                     cell_type
// m_axis   out  face_slot_out, face_id, face_owner, face_neighbor,     status
//               is_boundary, faces_total
//
// An area-cell edge scans the stored faces from the first one up to the face count:
// the single read port of the face memory feeds the compare unit one stored face per cycle,
// stopping at the first match. Line edges are appended without a scan and vertex edges are skipped.
// The block takes one transaction at a time. Reset clears the face count and control state;
// the face memory is not cleared.
// A stalled output holds its result while the next transaction is already accepted.
module mesh_face_table_builder_top #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int NODE_ID_BITS = 16,
    parameter int CELL_ID_BITS = 16,
    localparam int AW     = $clog2(TABLE_DEPTH),
    localparam int CW     = $clog2(TABLE_DEPTH + 1),
    localparam int IN_W   = CELL_ID_BITS + 3 + 2 * NODE_ID_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 3 + AW + 2 * (CELL_ID_BITS + 1) + 1 + CW,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_id, face_slot, node_a, node_b
    input  logic [IN_TW-1:0]                    s_tdata,
    // cell_type
    input  logic [mftb_pkg::TYPE_BITS-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // face_slot_out, face_id, face_owner, face_neighbor, is_boundary, faces_total
    output logic [OUT_TW-1:0]                   m_tdata,
    // status
    output logic [mftb_pkg::STATUS_BITS-1:0]    m_tuser
);
    import mftb_pkg::*;

    localparam int NB  = NODE_ID_BITS;
    localparam int CB  = CELL_ID_BITS;
    localparam int FW  = CB + 1;
    localparam int EW  = 2 * NB + 2 * FW + 1;
    localparam int E_HI  = NB;
    localparam int E_OWN = 2 * NB;
    localparam int E_NBR = 2 * NB + FW;
    localparam int E_BND = 2 * NB + 2 * FW;

    localparam logic [FW-1:0] NO_CELL   = '1;
    localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;

    logic [EW-1:0] face_mem [TABLE_DEPTH];

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [EW-1:0]     rd_data_reg;
    logic [CB-1:0]     cell_reg, cell_next;
    logic [2:0]        slot_reg, slot_next;
    logic [NB-1:0]     lo_reg, lo_next;
    logic [NB-1:0]     hi_reg, hi_next;
    logic              line_reg, line_next;
    logic [2:0]        r_status_reg, r_status_next;
    logic [AW-1:0]     r_id_reg, r_id_next;
    logic [FW-1:0]     r_own_reg, r_own_next;
    logic [FW-1:0]     r_nbr_reg, r_nbr_next;
    logic              r_bnd_reg, r_bnd_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg;
    logic [2:0]        m_slot_reg;
    logic [AW-1:0]     m_id_reg;
    logic [FW-1:0]     m_own_reg;
    logic [FW-1:0]     m_nbr_reg;
    logic              m_bnd_reg;
    logic [CW-1:0]     m_total_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic              load_out;
    logic              key_match;
    logic [CB-1:0]     in_cell;
    logic [2:0]        in_slot;
    logic [NB-1:0]     in_a;
    logic [NB-1:0]     in_b;
    logic [FW-1:0]     cell_ext;

    assign in_cell = s_tdata[CB-1:0];
    assign in_slot = s_tdata[CB+2:CB];
    assign in_a    = s_tdata[CB+3+NB-1:CB+3];
    assign in_b    = s_tdata[CB+3+2*NB-1:CB+3+NB];
    assign cell_ext = {1'b0, cell_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign key_match = (rd_data_reg[NB-1:0] == lo_reg) &&
                       (rd_data_reg[E_HI+NB-1:E_HI] == hi_reg);
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cell_next     = cell_reg;
        slot_next     = slot_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        line_next     = line_reg;
        r_status_next = r_status_reg;
        r_id_next     = r_id_reg;
        r_own_next    = r_own_reg;
        r_nbr_next    = r_nbr_reg;
        r_bnd_next    = r_bnd_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = rd_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cell_next = in_cell;
                    slot_next = in_slot;
                    lo_next   = (in_a < in_b) ? in_a : in_b;
                    hi_next   = (in_a < in_b) ? in_b : in_a;
                    line_next = (s_tuser < TYPE_LINE_LIMIT);
                    scan_next = '0;
                    if (s_tuser < TYPE_VERTEX_LIMIT)
                    begin
                        r_status_next = ST_SKIPPED;
                        r_id_next     = '0;
                        r_own_next    = NO_CELL;
                        r_nbr_next    = NO_CELL;
                        r_bnd_next    = 1'b0;
                        state_next    = S_EMIT;
                    end
                    else if (s_tuser < TYPE_LINE_LIMIT)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && key_match)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = pend_idx_reg;
                    r_id_next = pend_idx_reg;
                    r_bnd_next = rd_data_reg[E_BND];
                    if (rd_data_reg[E_BND])
                    begin
                        wr_data[E_OWN+FW-1:E_OWN] = cell_ext;
                        r_status_next = ST_OWNER_SET;
                        r_own_next    = cell_ext;
                        r_nbr_next    = rd_data_reg[E_NBR+FW-1:E_NBR];
                    end
                    else
                    begin
                        wr_data[E_NBR+FW-1:E_NBR] = cell_ext;
                        r_status_next = ST_NBR_SET;
                        r_own_next    = rd_data_reg[E_OWN+FW-1:E_OWN];
                        r_nbr_next    = cell_ext;
                    end
                    state_next = S_EMIT;
                end
                else if (scan_reg != count_reg)
                begin
                    rd_en         = 1'b1;
                    scan_next     = scan_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                end
                else if (!pend_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_APPEND:
            begin
                if (count_reg == FULL_CNT)
                begin
                    r_status_next = ST_FULL;
                    r_id_next     = '0;
                    r_own_next    = NO_CELL;
                    r_nbr_next    = NO_CELL;
                    r_bnd_next    = 1'b0;
                end
                else
                begin
                    wr_en         = 1'b1;
                    r_status_next = ST_NEW_FACE;
                    r_id_next     = count_reg[AW-1:0];
                    r_own_next    = line_reg ? NO_CELL : cell_ext;
                    r_nbr_next    = line_reg ? cell_ext : NO_CELL;
                    r_bnd_next    = line_reg;
                    wr_data       = {line_reg, r_nbr_next, r_own_next, hi_reg, lo_reg};
                    count_next    = count_reg + CW'(1);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            face_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= face_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        cell_reg     <= cell_next;
        slot_reg     <= slot_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        line_reg     <= line_next;
        r_status_reg <= r_status_next;
        r_id_reg     <= r_id_next;
        r_own_reg    <= r_own_next;
        r_nbr_reg    <= r_nbr_next;
        r_bnd_reg    <= r_bnd_next;
        if (load_out)
        begin
            m_status_reg <= r_status_reg;
            m_slot_reg   <= slot_reg;
            m_id_reg     <= r_id_reg;
            m_own_reg    <= r_own_reg;
            m_nbr_reg    <= r_nbr_reg;
            m_bnd_reg    <= r_bnd_reg;
            m_total_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = OUT_TW'({m_total_reg, m_bnd_reg, m_nbr_reg, m_own_reg,
                               m_id_reg, m_slot_reg});

    // The face count never runs past the table depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("face count exceeds table depth");

    // A newly appended face is always the last one in the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_NEW_FACE) |->
        ({1'b0, m_id_reg} == m_total_reg - CW'(1)))
        else $error("new face id does not match face count");

    // A full result is only reported with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_FULL) |-> (m_total_reg == FULL_CNT))
        else $error("table full reported with free entries");

    // A match is only taken on a compare whose memory read was issued the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(rd_en))
        else $error("compare without a pending read");

endmodule
